// ===== rtl/vmm_pkg.sv =====
// Shared types and constants for the video memory map block.
// Used by vmm_decode, vmm_nt_ram and video_memory_map_mirroring; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vmm_pkg;

  // Nametable geometry: two pages of one KiB each
  localparam int unsigned NtPageBytes = 1024;
  localparam int unsigned NtDepth     = 2 * NtPageBytes;
  localparam int unsigned NtWithinW   = $clog2(NtPageBytes);
  localparam int unsigned NtAddrW     = $clog2(NtDepth);

  // Palette geometry
  localparam int unsigned PalDepth = 32;
  localparam int unsigned PalIdxW  = $clog2(PalDepth);

  // Address map of the folded 14-bit video bus
  localparam int unsigned VAddrW      = 14;
  localparam logic [13:0] PalBase     = 14'h3F00;
  localparam logic [13:0] NtBase      = 14'h2000;
  localparam logic [15:0] LowByteMask = 16'h00FF;

  // Request codes
  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Mirror modes; codes above MIR_UNMAPPED are treated as unmapped
  typedef enum logic [2:0] {
    MIR_HORIZ    = 3'd0,
    MIR_VERT     = 3'd1,
    MIR_SINGLE_L = 3'd2,
    MIR_SINGLE_H = 3'd3,
    MIR_UNMAPPED = 3'd4
  } mirror_e;

  // Input item
  typedef struct packed {
    req_e        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [2:0]  mirror_mode;
    logic [4:0]  palette_index;
  } vmm_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       open_bus;
  } vmm_out_t;

  // Decoded location of one access
  typedef struct packed {
    logic               hit_pal;
    logic               hit_nt;
    logic [PalIdxW-1:0] pal_idx;
    logic [NtAddrW-1:0] nt_addr;
  } vmm_dec_t;

endpackage

`default_nettype wire

// ===== rtl/vmm_decode.sv =====
// Address decoder: folds the video bus address and resolves palette aliasing
// and nametable mirroring. Depends on vmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmm_decode (
  input  logic [15:0]       address_i,
  input  logic [2:0]        mirror_mode_i,
  output vmm_pkg::vmm_dec_t dec_o
);

  logic [vmm_pkg::VAddrW-1:0]    fold_addr;
  logic [11:0]                   nt_off;
  logic [1:0]                    quad;
  logic                          page;
  logic                          page_ok;
  logic [vmm_pkg::PalIdxW-1:0]   pal_raw;

  // Fold to 14 bits; nametable offset within the 4 KiB window
  assign fold_addr = address_i[vmm_pkg::VAddrW-1:0];
  assign nt_off    = fold_addr[11:0];
  assign quad      = nt_off[vmm_pkg::NtWithinW+1:vmm_pkg::NtWithinW];
  assign pal_raw   = fold_addr[vmm_pkg::PalIdxW-1:0];

  // Select the RAM page from the mirror mode
  always_comb begin
    page    = 1'b0;
    page_ok = 1'b1;
    unique case (vmm_pkg::mirror_e'(mirror_mode_i))
      vmm_pkg::MIR_HORIZ:    page = quad[1];
      vmm_pkg::MIR_VERT:     page = quad[0];
      vmm_pkg::MIR_SINGLE_L: page = 1'b0;
      vmm_pkg::MIR_SINGLE_H: page = 1'b1;
      default:               page_ok = 1'b0;
    endcase
  end

  // Classify the region and form the storage index
  always_comb begin
    dec_o.hit_pal = 1'b0;
    dec_o.hit_nt  = 1'b0;
    dec_o.pal_idx = pal_raw;
    dec_o.nt_addr = {page, nt_off[vmm_pkg::NtWithinW-1:0]};
    // Entry zero of each sprite palette aliases entry zero of the matching background palette
    if (pal_raw[4] && (pal_raw[1:0] == 2'b00)) begin
      dec_o.pal_idx = {1'b0, pal_raw[3:0]};
    end
    if (fold_addr >= vmm_pkg::PalBase) begin
      dec_o.hit_pal = 1'b1;
    end else if (fold_addr >= vmm_pkg::NtBase) begin
      dec_o.hit_nt = page_ok;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vmm_nt_ram.sv =====
// Nametable RAM: 2 KiB, one port, registered read, zero fill sweep after reset.
// Depends on vmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmm_nt_ram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic                        rd_en_i,
  input  logic [vmm_pkg::NtAddrW-1:0] addr_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o,
  output logic                        busy_o
);

  logic [7:0]                  mem [vmm_pkg::NtDepth];
  logic [vmm_pkg::NtAddrW-1:0] clr_cnt_q;
  logic                        busy_q;
  logic [7:0]                  rdata_q;

  // Sweep every entry once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == vmm_pkg::NtAddrW'(vmm_pkg::NtDepth - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Storage: clear writes take the port while busy
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= 8'h00;
    end else if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

// ===== rtl/video_memory_map_mirroring.sv =====
// Video memory map: one item per cycle when not stalled; the result is registered in the cycle after acceptance.
// Throughput is one item per cycle while out_ready_i is high; the single
// result register stalls input when a result is not taken.
// After reset the nametable RAM is zero-filled one entry per cycle:
// in_ready_o stays low until every entry is cleared. Palette bytes reset to zero at once.
// Depends on vmm_pkg, vmm_decode and vmm_nt_ram.
`timescale 1ns / 1ps
`default_nettype none

module video_memory_map_mirroring (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vmm_pkg::vmm_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vmm_pkg::vmm_out_t out_o
);

  vmm_pkg::vmm_dec_t           dec;
  logic                        accept;
  logic                        nt_busy;
  logic [7:0]                  nt_rdata;
  logic                        nt_we;
  logic                        nt_re;
  logic                        pal_we;
  logic [vmm_pkg::PalIdxW-1:0] pal_rd_idx;
  logic [7:0]                  pal_q [vmm_pkg::PalDepth];

  logic       valid_q;
  logic       sel_nt_d, sel_nt_q;
  logic [7:0] byte_d, byte_q;
  logic       ob_d, ob_q;

  vmm_decode u_decode (
    .address_i     (in_i.address),
    .mirror_mode_i (in_i.mirror_mode),
    .dec_o         (dec)
  );

  vmm_nt_ram u_nt_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (nt_we),
    .rd_en_i (nt_re),
    .addr_i  (dec.nt_addr),
    .wdata_i (in_i.write_data),
    .rdata_o (nt_rdata),
    .busy_o  (nt_busy)
  );

  // Take an item when the result register is free or being drained
  assign in_ready_o = !nt_busy && (!valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // One palette read port: direct lookup or aliased address
  assign pal_rd_idx = (in_i.req_type == vmm_pkg::REQ_LOOKUP) ? in_i.palette_index
                                                             : dec.pal_idx;

  // Dispatch the request
  always_comb begin
    sel_nt_d = 1'b0;
    byte_d   = 8'h00;
    ob_d     = 1'b0;
    pal_we   = 1'b0;
    nt_we    = 1'b0;
    nt_re    = 1'b0;
    unique case (in_i.req_type)
      vmm_pkg::REQ_READ: begin
        if (dec.hit_pal) begin
          byte_d = pal_q[pal_rd_idx];
        end else if (dec.hit_nt) begin
          sel_nt_d = 1'b1;
          nt_re    = accept;
        end else begin
          byte_d = 8'(in_i.address & vmm_pkg::LowByteMask);
          ob_d   = 1'b1;
        end
      end
      vmm_pkg::REQ_WRITE: begin
        if (dec.hit_pal) begin
          pal_we = accept;
        end else if (dec.hit_nt) begin
          nt_we = accept;
        end else begin
          ob_d = 1'b1;
        end
      end
      vmm_pkg::REQ_LOOKUP: begin
        byte_d = pal_q[pal_rd_idx];
      end
      vmm_pkg::REQ_NONE: begin
      end
    endcase
  end

  // Palette bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vmm_pkg::PalDepth; i++) begin
        pal_q[i] <= 8'h00;
      end
    end else if (pal_we) begin
      pal_q[dec.pal_idx] <= in_i.write_data;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sel_nt_q <= sel_nt_d;
      byte_q   <= byte_d;
      ob_q     <= ob_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_o.read_data = sel_nt_q ? nt_rdata : byte_q;
  assign out_o.open_bus  = ob_q;

  // Nothing enters while the nametable is still being cleared
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !nt_busy)
    else $error("item accepted during nametable clear");

  // A write yields a zero data byte in the next result
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.req_type == vmm_pkg::REQ_WRITE))
      |=> (out_valid_o && (out_o.read_data == 8'h00)))
    else $error("write result carries nonzero data");

  // A direct lookup never reports open bus
  a_lookup_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.req_type == vmm_pkg::REQ_LOOKUP))
      |=> (out_valid_o && !out_o.open_bus))
    else $error("palette lookup flagged open bus");

  // Open bus results never come from the nametable RAM
  a_ob_not_nt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ob_q) |-> !sel_nt_q)
    else $error("open bus result selected nametable data");

endmodule

`default_nettype wire

// ===== tb/vmm_checker.sv =====
// Scoreboard for the video memory map: watches both channels, predicts each result
// from its own copy of nametable and palette memory, and counts mismatches.
// Depends on vmm_pkg.
`timescale 1ns / 1ps

module vmm_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  vmm_pkg::vmm_in_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  vmm_pkg::vmm_out_t out_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       open_bus_seen_o
);
  import vmm_pkg::*;

  // Shadow copies of the two memories
  logic [7:0] nt_shadow [NtDepth];
  logic [7:0] pal_shadow [PalDepth];

  // Results still owed by the block, oldest first
  vmm_out_t owed_results [$];

  // Decode one access, update the shadow memories and return the result it causes
  function automatic vmm_out_t apply_access(vmm_in_t acc);
    vmm_out_t res;
    logic [13:0] folded;
    logic [11:0] nt_off;
    logic [15:0] low_byte;
    logic [4:0] pal_slot;
    logic [NtAddrW-1:0] nt_slot;
    logic page;
    logic served;
    logic to_pal;
    res = '0;
    served = 1'b1;
    to_pal = 1'b0;
    page = 1'b0;
    pal_slot = '0;
    folded = acc.address[13:0];
    if (folded >= PalBase) begin
      // Sprite backdrop entries fold onto the background ones
      to_pal = 1'b1;
      pal_slot = folded[4:0];
      if ((pal_slot & 5'h13) == 5'h10) pal_slot = pal_slot & 5'h0F;
    end else if (folded >= NtBase) begin
      // Fold $3000-$3EFF onto $2000-$2EFF, then pick the page by mirror mode
      nt_off = 12'((folded & 14'h2FFF) - NtBase);
      case (acc.mirror_mode)
        MIR_HORIZ:    page = nt_off[11];
        MIR_VERT:     page = nt_off[10];
        MIR_SINGLE_L: page = 1'b0;
        MIR_SINGLE_H: page = 1'b1;
        default:      served = 1'b0;
      endcase
    end else begin
      served = 1'b0;
    end
    nt_slot = {page, nt_off[NtWithinW-1:0]};

    case (acc.req_type)
      REQ_READ: begin
        if (!served) begin
          low_byte = acc.address & LowByteMask;
          res.read_data = low_byte[7:0];
          res.open_bus = 1'b1;
        end else if (to_pal) begin
          res.read_data = pal_shadow[pal_slot];
        end else begin
          res.read_data = nt_shadow[nt_slot];
        end
      end
      REQ_WRITE: begin
        if (!served) begin
          res.open_bus = 1'b1;
        end else if (to_pal) begin
          pal_shadow[pal_slot] = acc.write_data;
        end else begin
          nt_shadow[nt_slot] = acc.write_data;
        end
      end
      REQ_LOOKUP: res.read_data = pal_shadow[acc.palette_index];
      default: res = '0;
    endcase
    return res;
  endfunction

  // Compare each taken result against the oldest owed one, then log new items
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    vmm_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NtDepth; i++) nt_shadow[i] = '0;
      for (int i = 0; i < PalDepth; i++) pal_shadow[i] = '0;
      owed_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      open_bus_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result read_data=%02h open_bus=%0b",
                     $realtime, out_i.read_data, out_i.open_bus);
        end else begin
          want = owed_results.pop_front();
          checked_o++;
          if (out_i.open_bus === 1'b1) open_bus_seen_o++;
          if (out_i.read_data !== want.read_data || out_i.open_bus !== want.open_bus) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch read_data exp=%02h got=%02h, open_bus exp=%0b got=%0b",
                       $realtime, want.read_data, out_i.read_data,
                       want.open_bus, out_i.open_bus);
          end
        end
      end
      if (in_valid_i && in_ready_i) owed_results.push_back(apply_access(in_i));
      pending_o = owed_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the video memory map testbench: clock, reset, stimulus and verdict.
// Instantiates video_memory_map_mirroring and vmm_checker; depends on vmm_pkg.
`timescale 1ns / 1ps

module testbench;
  import vmm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 338;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  vmm_in_t  in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  vmm_out_t out_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned open_bus_seen;
  int unsigned sent_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  video_memory_map_mirroring dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  vmm_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_i            (in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_i           (out_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .open_bus_seen_o (open_bus_seen)
  );

  // Free-running clock, 2 ns period
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: drop ready at random per the current stall rate
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  function automatic vmm_in_t make_access(req_e req, logic [15:0] addr, logic [7:0] data,
                                          logic [2:0] mode, logic [4:0] idx);
    vmm_in_t acc;
    acc.req_type = req;
    acc.address = addr;
    acc.write_data = data;
    acc.mirror_mode = mode;
    acc.palette_index = idx;
    return acc;
  endfunction

  // Offer one item, idling first at random; hold it until accepted
  task automatic send_access(input vmm_in_t acc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= acc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Random accesses, weighted toward served regions and a small set of offsets
  task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    vmm_in_t acc;
    logic [2:0] sticky_mode;
    logic [13:0] folded;
    logic [11:0] nt_off;
    int unsigned pick;
    sender_idle_pct = idle_pct;
    receiver_stall_pct <= stall_pct;
    sticky_mode = 3'($urandom_range(MIR_SINGLE_H, MIR_HORIZ));
    for (int n = 0; n < count; n++) begin
      acc.write_data = 8'($urandom_range(255));
      acc.palette_index = 5'($urandom_range(31));

      pick = $urandom_range(99);
      if (pick < 40) acc.req_type = REQ_READ;
      else if (pick < 80) acc.req_type = REQ_WRITE;
      else if (pick < 94) acc.req_type = REQ_LOOKUP;
      else acc.req_type = REQ_NONE;

      // Keep the mirror mode mostly stable so reads see earlier writes
      if ($urandom_range(99) < 5)
        sticky_mode = 3'($urandom_range(MIR_SINGLE_H, MIR_HORIZ));
      pick = $urandom_range(99);
      if (pick < 85) acc.mirror_mode = sticky_mode;
      else if (pick < 93) acc.mirror_mode = MIR_UNMAPPED;
      else acc.mirror_mode = 3'($urandom_range(3'd7, MIR_UNMAPPED + 1));

      pick = $urandom_range(99);
      if (pick < 55) begin
        nt_off[11:10] = 2'($urandom_range(3));
        nt_off[9:0] = $urandom_range(1) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
        folded = NtBase + 14'(nt_off);
        if ($urandom_range(3) == 0 && nt_off < 12'hF00) folded = folded | 14'h1000;
      end else if (pick < 75) begin
        folded = PalBase | 14'($urandom_range(255));
      end else if (pick < 85) begin
        folded = 14'($urandom_range(14'h1FFF));
      end else begin
        folded = 14'($urandom_range(14'h3FFF));
      end
      acc.address = {2'($urandom_range(3)), folded};
      send_access(acc);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    sent_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: region edges, each mirror mode, palette aliasing, unused codes
    send_access(make_access(REQ_READ, 16'h0000, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_READ, 16'h1FFF, 8'h00, MIR_VERT, 5'd0));
    send_access(make_access(REQ_WRITE, 16'h2000, 8'hFF, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_READ, 16'h2400, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_READ, 16'h2800, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_READ, 16'h2800, 8'h00, MIR_VERT, 5'd0));
    send_access(make_access(REQ_WRITE, 16'h2FFF, 8'hA5, MIR_SINGLE_H, 5'd31));
    send_access(make_access(REQ_READ, 16'h27FF, 8'h00, MIR_VERT, 5'd0));
    send_access(make_access(REQ_READ, 16'h3BFF, 8'h00, MIR_SINGLE_H, 5'd0));
    send_access(make_access(REQ_READ, 16'h3EFF, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_READ, 16'hE000, 8'h00, MIR_SINGLE_L, 5'd0));
    send_access(make_access(REQ_WRITE, 16'h2000, 8'h5A, MIR_UNMAPPED, 5'd0));
    send_access(make_access(REQ_READ, 16'h2000, 8'h00, MIR_SINGLE_L, 5'd0));
    send_access(make_access(REQ_READ, 16'h23C7, 8'h00, 3'd7, 5'd0));
    send_access(make_access(REQ_WRITE, 16'h3F10, 8'h3C, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_LOOKUP, 16'h0000, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_LOOKUP, 16'h0000, 8'h00, MIR_HORIZ, 5'd16));
    send_access(make_access(REQ_READ, 16'h3F00, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_WRITE, 16'h3F04, 8'h11, MIR_VERT, 5'd0));
    send_access(make_access(REQ_READ, 16'h3F14, 8'h00, MIR_VERT, 5'd0));
    send_access(make_access(REQ_WRITE, 16'hFFFF, 8'h80, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_READ, 16'hFF1F, 8'h00, MIR_HORIZ, 5'd0));
    send_access(make_access(REQ_LOOKUP, 16'hFFFF, 8'hFF, 3'd7, 5'd31));
    send_access(make_access(REQ_NONE, 16'h2000, 8'hFF, MIR_HORIZ, 5'd31));

    // Random: no idling, mostly idle sender, stalling receiver, light idling on both
    run_phase(PhaseItems, 0, 0);
    run_phase(PhaseItems, 80, 0);
    run_phase(PhaseItems, 0, 80);
    run_phase(PhaseItems, 14, 14);

    // Drain what is still owed, then keep the clock running to catch stray results
    in_valid_i <= 1'b0;
    receiver_stall_pct <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d accesses over four idling phases after a directed set.", sent_count);
    $display("Compared %0d results, %0d of them open bus; %0d mismatches.",
             checked, open_bus_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
